/* hw/rtl/xec_pkg.sv */
`timescale 1ns / 1ps
package xec_pkg;

    // Longest entity name buffered after '&' before the token counts as overlong
    localparam int MAX_ENT    = 4;
    localparam int NUM_ENT    = 5;
    localparam int NAME_W     = 4;
    localparam int NAME_IDX_W = $clog2(NAME_W);
    localparam int ENT_IDX_W  = $clog2(NUM_ENT);
    localparam int ENT_LEN_W  = $clog2(NAME_W + 1);
    localparam int CNT_W      = $clog2(MAX_ENT + 1);
    localparam int IDX_W      = $clog2(MAX_ENT);
    localparam int MAX_RUN    = MAX_ENT + 2;
    localparam int RUN_CNT_W  = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W  = $clog2(MAX_RUN);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    typedef logic [ENT_IDX_W-1:0] ent_idx_t;

    localparam ent_idx_t ENT_GT   = ENT_IDX_W'(0);
    localparam ent_idx_t ENT_LT   = ENT_IDX_W'(1);
    localparam ent_idx_t ENT_QUOT = ENT_IDX_W'(2);
    localparam ent_idx_t ENT_APOS = ENT_IDX_W'(3);
    localparam ent_idx_t ENT_AMP  = ENT_IDX_W'(4);

    // One output run: bytes[0..cnt-1] go out in order
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    marker;   // empty end marker, byte_valid = 0
        logic                    str_end;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    function automatic logic [7:0] ent_char(input ent_idx_t k);
        logic [7:0] c;
        unique case (k)
            ENT_GT:   c = CH_GT;
            ENT_LT:   c = CH_LT;
            ENT_QUOT: c = CH_QUOT;
            ENT_APOS: c = CH_APOS;
            ENT_AMP:  c = CH_AMP;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [ENT_LEN_W-1:0] ent_len(input ent_idx_t k);
        logic [ENT_LEN_W-1:0] n;
        unique case (k)
            ENT_GT:   n = ENT_LEN_W'(2);
            ENT_LT:   n = ENT_LEN_W'(2);
            ENT_QUOT: n = ENT_LEN_W'(4);
            ENT_APOS: n = ENT_LEN_W'(4);
            ENT_AMP:  n = ENT_LEN_W'(3);
            default:  n = '0;
        endcase
        return n;
    endfunction

    // gt lt quot apos amp, zero padded
    function automatic logic [7:0] ent_name(input ent_idx_t k, input logic [NAME_IDX_W-1:0] i);
        logic [NAME_W-1:0][7:0] s;
        unique case (k)
            ENT_GT:   s = {8'h00, 8'h00, 8'h74, 8'h67};
            ENT_LT:   s = {8'h00, 8'h00, 8'h74, 8'h6C};
            ENT_QUOT: s = {8'h74, 8'h6F, 8'h75, 8'h71};
            ENT_APOS: s = {8'h73, 8'h6F, 8'h70, 8'h61};
            ENT_AMP:  s = {8'h00, 8'h70, 8'h6D, 8'h61};
            default:  s = '0;
        endcase
        return s[i];
    endfunction

endpackage

/* hw/rtl/xec_front.sv */
`timescale 1ns / 1ps
module xec_front
    import xec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_ready,
    output logic       in_ready,
    output push_t      push
);

    logic                    mode_reg;
    logic                    phase_reg, phase_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MAX_ENT-1:0][7:0] buf_reg, buf_next;

    logic                    accept;
    logic                    is_end;
    logic                    enc_hit, dec_hit;
    ent_idx_t                enc_k, dec_k;
    logic                    match;
    logic                    single_en, amp_en, tail_en;
    logic [7:0]              single_byte, tail_byte;
    logic [MAX_ENT-1:0][7:0] seq;
    logic [CNT_W-1:0]        seq_len;
    logic [RUN_CNT_W-1:0]    run_cnt;
    cmd_t                    cmd;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign is_end   = in_last || (in_byte == 8'h00);

    // encode lookup on the incoming byte
    always_comb begin
        enc_hit = 1'b0;
        enc_k   = ENT_GT;
        for (int k = 0; k < NUM_ENT; k++) begin
            if (!enc_hit && in_byte == ent_char(ENT_IDX_W'(k))) begin
                enc_hit = 1'b1;
                enc_k   = ENT_IDX_W'(k);
            end
        end
    end

    // decode lookup on the buffered token
    always_comb begin
        dec_hit = 1'b0;
        dec_k   = ENT_GT;
        for (int k = 0; k < NUM_ENT; k++) begin
            match = (CNT_W'(ent_len(ENT_IDX_W'(k))) == cnt_reg);
            for (int i = 0; i < NAME_W; i++) begin
                if (ENT_LEN_W'(i) < ent_len(ENT_IDX_W'(k)) &&
                    buf_reg[i] != ent_name(ENT_IDX_W'(k), NAME_IDX_W'(i))) begin
                    match = 1'b0;
                end
            end
            if (!dec_hit && match) begin
                dec_hit = 1'b1;
                dec_k   = ENT_IDX_W'(k);
            end
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        buf_next    = buf_reg;
        single_en   = 1'b0;
        single_byte = in_byte;
        amp_en      = 1'b0;
        tail_en     = 1'b0;
        tail_byte   = CH_SEMI;
        seq         = buf_reg;
        seq_len     = cnt_reg;
        if (in_byte != 8'h00) begin
            if (!mode_reg) begin
                if (enc_hit) begin
                    amp_en  = 1'b1;
                    tail_en = 1'b1;
                    seq_len = CNT_W'(ent_len(enc_k));
                    for (int i = 0; i < MAX_ENT; i++) begin
                        seq[i] = (i < NAME_W) ? ent_name(enc_k, NAME_IDX_W'(i)) : 8'h00;
                    end
                end else begin
                    single_en = 1'b1;
                end
            end else if (!phase_reg) begin
                if (in_byte == CH_AMP) begin
                    phase_next = 1'b1;
                    cnt_next   = '0;
                end else begin
                    single_en = 1'b1;
                end
            end else if (in_byte == CH_SEMI) begin
                phase_next = 1'b0;
                cnt_next   = '0;
                if (dec_hit) begin
                    single_en   = 1'b1;
                    single_byte = ent_char(dec_k);
                end else begin
                    amp_en  = 1'b1;
                    tail_en = 1'b1;
                end
            end else if (cnt_reg >= CNT_W'(MAX_ENT)) begin
                // overlong token goes out as is, with the offending byte
                phase_next = 1'b0;
                cnt_next   = '0;
                amp_en     = 1'b1;
                tail_en    = 1'b1;
                tail_byte  = in_byte;
            end else begin
                buf_next[cnt_reg[IDX_W-1:0]] = in_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        // string end flushes a partial entity
        if (is_end && phase_next) begin
            amp_en     = 1'b1;
            seq        = buf_next;
            seq_len    = cnt_next;
            phase_next = 1'b0;
            cnt_next   = '0;
        end
    end

    always_comb begin
        run_cnt = '0;
        if (single_en) begin
            run_cnt = RUN_CNT_W'(1);
        end else if (amp_en) begin
            run_cnt = RUN_CNT_W'(seq_len) + RUN_CNT_W'(1) + RUN_CNT_W'(tail_en);
        end

        cmd         = '0;
        cmd.str_end = is_end;
        if (single_en) begin
            cmd.bytes[0] = single_byte;
            cmd.cnt      = run_cnt;
        end else if (amp_en) begin
            cmd.bytes[0] = CH_AMP;
            for (int j = 0; j < MAX_ENT; j++) begin
                cmd.bytes[j+1] = (CNT_W'(j) < seq_len) ? seq[j] : tail_byte;
            end
            cmd.bytes[MAX_RUN-1] = tail_byte;
            cmd.cnt              = run_cnt;
        end else begin
            cmd.cnt    = RUN_CNT_W'(1);
            cmd.marker = 1'b1;
        end
    end

    assign push.push = accept && (run_cnt != '0 || is_end);
    assign push.cmd  = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (cfg_wr_en) begin
            mode_reg  <= cfg_wr_data;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg <= buf_next;
        end
    end

endmodule

/* hw/rtl/xec_queue.sv */
`timescale 1ns / 1ps
module xec_queue
    import xec_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  ready,
    output head_t head,
    input  logic  pop
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign ready      = (count_reg != QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    assign do_push = push.push && ready;
    assign do_pop  = pop && head.valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

/* hw/rtl/xec_back.sv */
`timescale 1ns / 1ps
module xec_back
    import xec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  head_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_byte_valid,
    output logic       out_run_last,
    output logic       out_str_end
);

    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 bv_reg, rl_reg, se_reg;
    logic                 load, at_last;

    assign load    = head.valid && (!valid_reg || out_ready);
    assign at_last = (RUN_CNT_W'(idx_reg) + RUN_CNT_W'(1)) >= head.cmd.cnt;
    assign pop     = load && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= at_last ? '0 : idx_reg + RUN_IDX_W'(1);
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head.cmd.bytes[idx_reg];
            bv_reg   <= !head.cmd.marker;
            rl_reg   <= at_last;
            se_reg   <= at_last && head.cmd.str_end;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bv_reg;
    assign out_run_last   = rl_reg;
    assign out_str_end    = se_reg;

endmodule

/* hw/rtl/xml_entity_codec_unit.sv */
`timescale 1ns / 1ps
// Streaming XML entity escaper / unescaper. One byte enters per request on
// the s_ side; cfg_wr_data picks the mode (0 escapes > < " ' & into "&gt;"
// style runs, 1 turns the five named entities back into their characters;
// unknown, overlong or unterminated tokens pass through as written). A zero
// byte or s_tlast ends the string: a partial entity is flushed, and the last
// result of the string carries string_end; an input that ends the string but
// yields no byte gives one empty marker (tuser bit 0 low). m_tlast marks the
// last result caused by each input. Rate: one input per cycle while each
// input yields at most one byte and m_tready stays high; an input yielding n
// results (up to six) occupies the output register for all n of them, one
// byte per cycle while m_tready is high. The two-entry run queue between the
// classifier and the serializer takes one further input while a run drains;
// after that the input stalls until the draining run's last byte is loaded
// into the output register. An input's first result passes through the run
// queue and then the output register. Writing the mode register drops any
// partial entity; write it only while the block is idle.
module xml_entity_codec_unit
    import xec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // decode_mode

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // is_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] out_byte, [8] string_end, [15:9] zero
    output logic        m_tlast,       // run_last
    output logic [0:0]  m_tuser        // [0] byte_valid
);

    push_t      push;
    head_t      head;
    logic       q_ready;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_bv, out_rl, out_se;

    // front: mode, entity state and run building
    xec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .q_ready     (q_ready),
        .in_ready    (s_tready),
        .push        (push)
    );

    // runs waiting for the serializer
    xec_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .ready   (q_ready),
        .head    (head),
        .pop     (pop)
    );

    // back: one byte per cycle into the output register while m_tready is high
    xec_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (out_byte),
        .out_byte_valid (out_bv),
        .out_run_last   (out_rl),
        .out_str_end    (out_se)
    );

    assign m_tdata    = {7'b0, out_se, out_byte};
    assign m_tlast    = out_rl;
    assign m_tuser[0] = out_bv;

    // an empty marker only ever closes a string
    a_marker_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[8] && m_tdata[7:0] == 8'h00))
        else $error("empty marker not at string end");

    // string end always falls on the last result of a run
    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> m_tlast)
        else $error("string_end without run_last");

    // the queue takes nothing while full, so input must stall
    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (head.valid && !q_ready) |-> !s_tready)
        else $error("input taken while run queue full");

endmodule
